>>> hw/rtl/mcd_pkg.sv
`timescale 1ns / 1ps

package mcd_pkg;

   // Field widths. Positions are signed Q2.28; velocities are signed with 28 fraction bits in 26 bits.
   localparam int POS_W       = 30;
   localparam int VEL_W       = 26;
   localparam int SCORE_W     = 32;
   localparam int SUM_W       = 20;
   localparam int LIMIT_W     = 16;
   localparam int ENTRY_W     = 4;
   localparam int START_DEPTH = 16;
   localparam int Q_FRAC      = 28;

   localparam int EPISODES = 16;
   localparam int EP_W     = $clog2(EPISODES + 1);

   // Cosine table: 0.0025 * cos(3x) at the Q2.28 scale never exceeds 671089 in magnitude.
   localparam int GRAV_DEPTH = 2048;
   localparam int GRAV_AW    = $clog2(GRAV_DEPTH);
   localparam int GRAV_W     = 21;

   localparam logic signed [VEL_W-1:0] ACCEL = 26'sd268435;
   localparam logic signed [VEL_W-1:0] VMAX  = 26'sd18790482;
   localparam logic signed [POS_W-1:0] XMAX  = 30'sd134217728;
   localparam logic signed [POS_W-1:0] XMIN  = -30'sd322122547;

   // About 3 / (2 pi) in Q0.32, turning a position into a fraction of a turn.
   localparam logic [31:0] TURN_K     = 32'd2050695827;
   localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;
   localparam logic [63:0] ONE_Q28    = 64'd268435456;

   localparam logic signed [POS_W-1:0] GOAL_RESET  = 30'sd131533373;
   localparam logic [LIMIT_W-1:0]      LIMIT_RESET = 16'd2500;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = POS_W;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_POSITION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT    = 1'b1;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_BEGIN = 2'd1,
      ACT_STEP  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      FORCE_COAST = 2'd0,
      FORCE_PUSH  = 2'd1,
      FORCE_PULL  = 2'd2
   } force_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic signed [VEL_W-1:0] velocity;
   } start_entry_type;

   typedef logic signed [GRAV_W-1:0] grav_type;
   typedef grav_type grav_table_type [GRAV_DEPTH];

   // Builds the gravity table at elaboration. Entry k holds cos(2 pi m / depth) / 400,
   // rounded half away from zero, with m folded into the first half turn. The cosine
   // is an eleven-term Taylor series with every term truncated.
   function automatic grav_table_type build_grav_table();
      grav_table_type     tbl;
      logic [63:0]        m;
      logic [63:0]        ang;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        mag;
      logic signed [63:0] c;
      for (int k = 0; k < GRAV_DEPTH; k++) begin
         m    = (k <= GRAV_DEPTH - k) ? 64'(k) : 64'(GRAV_DEPTH - k);
         ang  = (TWO_PI_Q28 * m + 64'(GRAV_DEPTH / 2)) / 64'(GRAV_DEPTH);
         x2   = (ang * ang) >> Q_FRAC;
         term = ONE_Q28;
         c    = $signed(ONE_Q28);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> Q_FRAC) / 64'((2 * n - 1) * (2 * n));
            if ((n % 2) == 1) begin
               c = c - $signed(term);
            end else begin
               c = c + $signed(term);
            end
         end
         if (!c[63]) begin
            mag    = ($unsigned(c) + 64'd200) / 64'd400;
            tbl[k] = GRAV_W'(mag);
         end else begin
            mag    = ($unsigned(-c) + 64'd200) / 64'd400;
            tbl[k] = GRAV_W'(64'd0 - mag);
         end
      end
      return tbl;
   endfunction

endpackage

>>> hw/rtl/mcd_gravity.sv
`timescale 1ns / 1ps

module mcd_gravity (
   input  logic                                  clock,
   input  logic                                  rd_en,
   input  logic signed [mcd_pkg::POS_W-1:0]      position,
   output logic signed [mcd_pkg::GRAV_W-1:0]     gravity
);

   localparam int PROD_W  = mcd_pkg::POS_W + 32;
   localparam int SCALE_W = 32 + mcd_pkg::GRAV_AW + 1;

   localparam mcd_pkg::grav_table_type GRAV_ROM = mcd_pkg::build_grav_table();

   logic signed [PROD_W-1:0]             turn_prod;
   logic [31:0]                          turn_frac;
   logic [SCALE_W-1:0]                   scaled;
   logic [mcd_pkg::GRAV_AW:0]            idx_full;
   logic [mcd_pkg::GRAV_AW-1:0]          idx;
   logic signed [mcd_pkg::GRAV_W-1:0]    gravity_ff;

   // The fraction of a turn is taken from the wrapped product, then rounded to
   // the nearest table entry; a full turn folds back onto entry zero.
   always_comb begin
      turn_prod = PROD_W'(position) * PROD_W'($signed(mcd_pkg::TURN_K));
      turn_frac = turn_prod[mcd_pkg::Q_FRAC +: 32];
      scaled    = SCALE_W'(turn_frac) * SCALE_W'(mcd_pkg::GRAV_DEPTH)
                  + SCALE_W'(64'h8000_0000);
      idx_full  = scaled[SCALE_W-1:32];
      if (idx_full >= (mcd_pkg::GRAV_AW + 1)'(mcd_pkg::GRAV_DEPTH)) begin
         idx = '0;
      end else begin
         idx = idx_full[mcd_pkg::GRAV_AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         gravity_ff <= GRAV_ROM[idx];
      end
   end

   assign gravity = gravity_ff;

endmodule

>>> hw/rtl/mountain_car_dynamics_step.sv
`timescale 1ns / 1ps

// Mountain-car simulator in signed Q2.28. Each request beat loads a start-state
// entry, begins an evaluation of sixteen episodes, or advances the car by one step;
// every request beat yields exactly one response beat with the car state, the
// episode and evaluation flags and the running step sum. The block takes no new
// request until the last one has updated the state: in the cycle a beat is accepted
// the current position goes through the 30x32 turn multiplier to address the cosine
// table, and the start-state memory is read for the next episode; then, once the
// response register is free, velocity and position are updated and written back,
// and only then can the next step read the new position. A response is written into
// an output register when its update completes and is held there, so a further
// request is accepted while a response waits.
// Configuration writes are taken at any time and should only be made while idle.
module mountain_car_dynamics_step (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [mcd_pkg::ENTRY_W-1:0]           req_entry_index,
   input  logic signed [mcd_pkg::POS_W-1:0]      req_start_position,
   input  logic signed [mcd_pkg::VEL_W-1:0]      req_start_velocity,
   input  logic signed [mcd_pkg::SCORE_W-1:0]    req_score_push,
   input  logic signed [mcd_pkg::SCORE_W-1:0]    req_score_coast,
   input  logic signed [mcd_pkg::SCORE_W-1:0]    req_score_pull,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mcd_pkg::POS_W-1:0]      rsp_position,
   output logic signed [mcd_pkg::VEL_W-1:0]      rsp_velocity,
   output logic                                  rsp_episode_ended,
   output logic                                  rsp_evaluation_done,
   output logic [mcd_pkg::SUM_W-1:0]             rsp_step_sum,

   input  logic                                  csr_write_enable,
   input  logic [mcd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [mcd_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   localparam int VRAW_W = mcd_pkg::VEL_W + 2;
   localparam int PRAW_W = mcd_pkg::POS_W + 1;

   // Configuration.
   logic signed [mcd_pkg::POS_W-1:0]   goal_ff;
   logic [mcd_pkg::LIMIT_W-1:0]        limit_ff;

   // Car and evaluation state.
   logic signed [mcd_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic signed [mcd_pkg::VEL_W-1:0]   vel_ff, vel_in;
   logic [mcd_pkg::LIMIT_W-1:0]        steps_ff, steps_in;
   logic [mcd_pkg::EP_W-1:0]           ep_ff, ep_in;
   logic [mcd_pkg::SUM_W-1:0]          total_ff, total_in;
   logic                               finished_ff, finished_in;

   // Start-state memory.
   mcd_pkg::start_entry_type           start_mem [mcd_pkg::START_DEPTH];
   mcd_pkg::start_entry_type           start_rd_ff;
   mcd_pkg::start_entry_type           start_wr;
   logic [mcd_pkg::ENTRY_W-1:0]        start_rd_addr;

   // Update stage.
   logic                               s1_valid_ff;
   mcd_pkg::action_type                s1_action_ff;
   mcd_pkg::force_type                 s1_force_ff;
   mcd_pkg::force_type                 force_sel;
   logic                               s1_fire;
   logic                               req_fire;

   logic signed [mcd_pkg::GRAV_W-1:0]  grav;
   logic signed [VRAW_W-1:0]           accel_term;
   logic signed [VRAW_W-1:0]           v_raw;
   logic signed [mcd_pkg::VEL_W-1:0]   v_step;
   logic signed [PRAW_W-1:0]           p_raw;
   logic signed [mcd_pkg::POS_W-1:0]   p_step;
   logic [mcd_pkg::LIMIT_W-1:0]        steps_next;
   logic [mcd_pkg::EP_W-1:0]           ep_plus;
   logic [mcd_pkg::SUM_W:0]            sum_raw;
   logic                               step_ended;
   logic                               ended;

   // Response register.
   logic                               rsp_valid_ff;
   logic signed [mcd_pkg::POS_W-1:0]   rsp_position_ff;
   logic signed [mcd_pkg::VEL_W-1:0]   rsp_velocity_ff;
   logic                               rsp_episode_ended_ff;
   logic                               rsp_evaluation_done_ff;
   logic [mcd_pkg::SUM_W-1:0]          rsp_step_sum_ff;

   assign req_ready = !s1_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign ep_plus   = ep_ff + mcd_pkg::EP_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff  <= mcd_pkg::GOAL_RESET;
         limit_ff <= mcd_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mcd_pkg::CSR_GOAL_POSITION: begin
               goal_ff <= $signed(csr_write_data[mcd_pkg::POS_W-1:0]);
            end
            mcd_pkg::CSR_STEP_LIMIT: begin
               limit_ff <= csr_write_data[mcd_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Accept side: saturate a loaded start state, settle the force from the scores
   // and pick the start entry that this beat may need.
   always_comb begin
      if (req_start_position > mcd_pkg::XMAX) begin
         start_wr.position = mcd_pkg::XMAX;
      end else if (req_start_position < mcd_pkg::XMIN) begin
         start_wr.position = mcd_pkg::XMIN;
      end else begin
         start_wr.position = req_start_position;
      end
      if (req_start_velocity > mcd_pkg::VMAX) begin
         start_wr.velocity = mcd_pkg::VMAX;
      end else if (req_start_velocity < -mcd_pkg::VMAX) begin
         start_wr.velocity = -mcd_pkg::VMAX;
      end else begin
         start_wr.velocity = req_start_velocity;
      end

      if (req_score_push > req_score_coast) begin
         force_sel = (req_score_push > req_score_pull) ? mcd_pkg::FORCE_PUSH
                                                       : mcd_pkg::FORCE_PULL;
      end else if (req_score_coast < req_score_pull) begin
         force_sel = mcd_pkg::FORCE_PULL;
      end else begin
         force_sel = mcd_pkg::FORCE_COAST;
      end

      if (mcd_pkg::action_type'(req_action) == mcd_pkg::ACT_BEGIN) begin
         start_rd_addr = '0;
      end else begin
         start_rd_addr = mcd_pkg::ENTRY_W'(ep_plus);
      end
   end

   // A load only writes and every other beat only reads, so the memory sees one
   // access per accepted beat, and a read of a loaded entry comes in a later
   // accepted beat than its write.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (mcd_pkg::action_type'(req_action) == mcd_pkg::ACT_LOAD) begin
            start_mem[req_entry_index] <= start_wr;
         end else begin
            start_rd_ff <= start_mem[start_rd_addr];
         end
      end
   end

   mcd_gravity u_gravity (
      .clock    (clock),
      .rd_en    (req_fire),
      .position (pos_ff),
      .gravity  (grav)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= mcd_pkg::action_type'(req_action);
         s1_force_ff  <= force_sel;
      end
   end

   // Step arithmetic, worked out every cycle and used only for a step beat.
   always_comb begin
      case (s1_force_ff)
         mcd_pkg::FORCE_PUSH: accel_term = VRAW_W'(mcd_pkg::ACCEL);
         mcd_pkg::FORCE_PULL: accel_term = -VRAW_W'(mcd_pkg::ACCEL);
         default:             accel_term = '0;
      endcase

      v_raw = VRAW_W'(vel_ff) + accel_term - VRAW_W'(grav);
      if (v_raw > VRAW_W'(mcd_pkg::VMAX)) begin
         v_step = mcd_pkg::VMAX;
      end else if (v_raw < -VRAW_W'(mcd_pkg::VMAX)) begin
         v_step = -mcd_pkg::VMAX;
      end else begin
         v_step = mcd_pkg::VEL_W'(v_raw);
      end

      p_raw = PRAW_W'(pos_ff) + PRAW_W'(v_step);
      if (p_raw > PRAW_W'(mcd_pkg::XMAX)) begin
         p_step = mcd_pkg::XMAX;
      end else if (p_raw < PRAW_W'(mcd_pkg::XMIN)) begin
         // The car stops dead against the left wall.
         p_step = mcd_pkg::XMIN;
         v_step = '0;
      end else begin
         p_step = mcd_pkg::POS_W'(p_raw);
      end

      steps_next = steps_ff + mcd_pkg::LIMIT_W'(1);
      step_ended = (p_step >= goal_ff) || (steps_next >= limit_ff);
      sum_raw    = (mcd_pkg::SUM_W + 1)'(total_ff) + (mcd_pkg::SUM_W + 1)'(steps_next);
   end

   always_comb begin
      pos_in      = pos_ff;
      vel_in      = vel_ff;
      steps_in    = steps_ff;
      ep_in       = ep_ff;
      total_in    = total_ff;
      finished_in = finished_ff;
      ended       = 1'b0;
      case (s1_action_ff)
         mcd_pkg::ACT_BEGIN: begin
            pos_in      = start_rd_ff.position;
            vel_in      = start_rd_ff.velocity;
            steps_in    = '0;
            ep_in       = '0;
            total_in    = '0;
            finished_in = 1'b0;
         end
         mcd_pkg::ACT_STEP: begin
            if (!finished_ff) begin
               if (step_ended) begin
                  ended    = 1'b1;
                  total_in = sum_raw[mcd_pkg::SUM_W] ? '1 : sum_raw[mcd_pkg::SUM_W-1:0];
                  ep_in    = ep_plus;
                  if (ep_plus < mcd_pkg::EP_W'(mcd_pkg::EPISODES)) begin
                     pos_in   = start_rd_ff.position;
                     vel_in   = start_rd_ff.velocity;
                     steps_in = '0;
                  end else begin
                     pos_in      = p_step;
                     vel_in      = v_step;
                     steps_in    = steps_next;
                     finished_in = 1'b1;
                  end
               end else begin
                  pos_in   = p_step;
                  vel_in   = v_step;
                  steps_in = steps_next;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         vel_ff      <= '0;
         steps_ff    <= '0;
         ep_ff       <= '0;
         total_ff    <= '0;
         finished_ff <= 1'b1;
      end else if (s1_fire) begin
         pos_ff      <= pos_in;
         vel_ff      <= vel_in;
         steps_ff    <= steps_in;
         ep_ff       <= ep_in;
         total_ff    <= total_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_position_ff        <= pos_in;
         rsp_velocity_ff        <= vel_in;
         rsp_episode_ended_ff   <= ended;
         rsp_evaluation_done_ff <= finished_in;
         rsp_step_sum_ff        <= total_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_position        = rsp_position_ff;
   assign rsp_velocity        = rsp_velocity_ff;
   assign rsp_episode_ended   = rsp_episode_ended_ff;
   assign rsp_evaluation_done = rsp_evaluation_done_ff;
   assign rsp_step_sum        = rsp_step_sum_ff;

   // The stored velocity always lies within the clamp limits.
   assert property (@(posedge clock) disable iff (reset)
      (vel_ff <= mcd_pkg::VMAX) && (vel_ff >= -mcd_pkg::VMAX))
      else $error("car velocity outside its limits");

   // Ending the last episode finishes the evaluation and reports it.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_action_ff == mcd_pkg::ACT_STEP) && !finished_ff && step_ended
       && (ep_plus == mcd_pkg::EP_W'(mcd_pkg::EPISODES)))
      |=> (finished_ff && rsp_evaluation_done))
      else $error("last episode ended without finishing the evaluation");

   // The car and evaluation state move only when a beat completes its update.
   assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> ($stable(pos_ff) && $stable(vel_ff) && $stable(total_ff)
                    && $stable(ep_ff) && $stable(finished_ff)))
      else $error("state changed without a completed beat");

   // Within an evaluation the step sum never falls.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_action_ff != mcd_pkg::ACT_BEGIN)) |=> (total_ff >= $past(total_ff)))
      else $error("step sum decreased outside a new evaluation");

endmodule
